>>> rtl/core/robot_mode_supervisor_top_assert.svh
// ----------------------------------------------------------------------------
// Robot mode supervisor assertion macros
// Shared macros for clocked assertions, disabled while reset rst is high.
// ----------------------------------------------------------------------------
`ifndef ROBOT_MODE_SUPERVISOR_TOP_ASSERT_SVH
`define ROBOT_MODE_SUPERVISOR_TOP_ASSERT_SVH

// Same-cycle implication
`define RMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rms_pkg.sv
// ----------------------------------------------------------------------------
// Robot mode supervisor package
// Word types, mode codes and motion command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

  localparam logic [2:0] MODE_INIT    = 3'd0;
  localparam logic [2:0] MODE_WAIT    = 3'd1;
  localparam logic [2:0] MODE_HOMING  = 3'd2;
  localparam logic [2:0] MODE_READY   = 3'd3;
  localparam logic [2:0] MODE_PAUSE   = 3'd4;
  localparam logic [2:0] MODE_RUNNING = 3'd5;
  localparam logic [2:0] MODE_FAULT   = 3'd6;

  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_HOME     = 3'd1;
  localparam logic [2:0] CMD_DWELL    = 3'd2;
  localparam logic [2:0] CMD_HOLD     = 3'd3;
  localparam logic [2:0] CMD_REST     = 3'd4;
  localparam logic [2:0] CMD_BACKOFF  = 3'd5;
  localparam logic [2:0] CMD_SEQUENCE = 3'd6;

  localparam logic [7:0] DEBOUNCE_LIMIT_RESET = 8'd25;
  localparam logic [7:0] DEBOUNCE_COUNT_MAX   = 8'hFF;

  typedef struct packed {
    logic start_pressed;
    logic stop_pressed;
    logic reset_pressed;
    logic emergency_edge;
    logic emergency_active;
    logic homing_done;
    logic hold_done;
    logic move_done;
    logic sequence_done;
  } in_word_t;

  typedef struct packed {
    logic [2:0] system_state;
    logic       state_changed;
    logic [2:0] motion_command;
    logic       planner_reset;
    logic       sequence_reset;
    logic       homing_reset;
    logic       outputs_off;
    logic       motors_disable;
    logic       loop_window_reset;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/core/robot_mode_supervisor_top.sv
// ----------------------------------------------------------------------------
// Robot mode supervisor
// One tick word in, one mode/command word out; emergency debounce and modes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | word
//  in      | input     | in_valid/in_stall   | in_word_t
//  out     | output    | out_valid/out_stall | out_word_t
//  cfg     | input     | cfg_valid/cfg_ready | debounce_limit, 8 bits
//
//  One tick per clock cycle while the output is not stalled: input register,
//  one pass of mode logic, result register. out_valid rises once the held
//  tick word is passed from the input register into the result register.
//  Synchronous reset rst clears the mode, flags, counter and debounce_limit
//  (back to 25). A stalled output word holds; the input register then fills
//  and in_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module robot_mode_supervisor_top
  import rms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] debounce_limit;
  logic [2:0] mode;
  logic       emergency_pending;
  logic [7:0] debounce_count;
  logic       motors_homed;
  logic       dwell_finished;
  logic       returning_to_rest;
  logic       going_to_backoff;

  in_word_t   in_hold;
  logic       in_full;

  logic       fire;

  logic [2:0] dbn_mode;
  logic       emergency_pending_next;
  logic [7:0] debounce_count_next;
  logic [7:0] count_sat;

  logic [2:0] mode_next;
  logic       motors_homed_next;
  logic       dwell_finished_next;
  logic       returning_to_rest_next;
  logic       going_to_backoff_next;
  out_word_t  res;

  assign fire      = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !fire;
  assign cfg_ready = 1'b1;

  // debounce
  always_comb begin
    dbn_mode               = mode;
    emergency_pending_next = emergency_pending;
    debounce_count_next    = debounce_count;
    count_sat = (debounce_count == DEBOUNCE_COUNT_MAX) ? debounce_count
                                                       : debounce_count + 8'd1;
    if (in_hold.emergency_edge) begin
      emergency_pending_next = 1'b1;
      debounce_count_next    = 8'd0;
    end else if (emergency_pending && in_hold.emergency_active) begin
      if (count_sat > debounce_limit) begin
        dbn_mode               = MODE_FAULT;
        emergency_pending_next = 1'b0;
        debounce_count_next    = 8'd0;
      end else begin
        debounce_count_next = count_sat;
      end
    end else if (emergency_pending) begin
      emergency_pending_next = 1'b0;
      debounce_count_next    = 8'd0;
    end
  end

  // mode step
  always_comb begin
    mode_next              = dbn_mode;
    motors_homed_next      = motors_homed;
    dwell_finished_next    = dwell_finished;
    returning_to_rest_next = returning_to_rest;
    going_to_backoff_next  = going_to_backoff;
    res                    = '0;
    res.motion_command     = CMD_NONE;
    if (mode == MODE_INIT) begin
      res.outputs_off    = 1'b1;
      res.motors_disable = 1'b1;
      mode_next = in_hold.emergency_active ? MODE_FAULT : MODE_WAIT;
    end else begin
      case (dbn_mode)
        MODE_WAIT: begin
          if (in_hold.start_pressed) begin
            motors_homed_next   = 1'b0;
            dwell_finished_next = 1'b0;
            mode_next           = MODE_HOMING;
          end
          res.outputs_off = 1'b1;
        end
        MODE_HOMING: begin
          if (!motors_homed) begin
            res.motion_command = CMD_HOME;
            motors_homed_next  = in_hold.homing_done;
            res.planner_reset  = in_hold.homing_done;
          end else if (!dwell_finished) begin
            res.motion_command  = CMD_DWELL;
            dwell_finished_next = in_hold.hold_done;
            res.planner_reset   = in_hold.hold_done;
          end else begin
            res.motion_command = CMD_REST;
            if (in_hold.move_done) begin
              res.planner_reset   = 1'b1;
              dwell_finished_next = 1'b0;
              mode_next           = MODE_READY;
            end
          end
        end
        MODE_READY: begin
          if (in_hold.start_pressed) begin
            res.loop_window_reset = 1'b1;
            res.sequence_reset    = 1'b1;
            mode_next             = MODE_RUNNING;
          end else if (in_hold.reset_pressed) begin
            res.loop_window_reset = 1'b1;
            motors_homed_next     = 1'b0;
            dwell_finished_next   = 1'b0;
            res.planner_reset     = 1'b1;
            going_to_backoff_next = 1'b1;
          end
          if (going_to_backoff_next) begin
            res.motion_command = CMD_BACKOFF;
            if (in_hold.move_done) begin
              going_to_backoff_next = 1'b0;
              mode_next             = MODE_HOMING;
            end
          end else begin
            res.motion_command = CMD_HOLD;
          end
        end
        MODE_PAUSE: begin
          if (returning_to_rest) begin
            res.motion_command = CMD_REST;
            if (in_hold.move_done) begin
              mode_next              = MODE_READY;
              res.planner_reset      = 1'b1;
              returning_to_rest_next = 1'b0;
            end
          end else begin
            res.motion_command = CMD_HOLD;
          end
          if (in_hold.start_pressed) begin
            mode_next             = MODE_RUNNING;
            res.planner_reset     = 1'b1;
            res.loop_window_reset = 1'b1;
          end
          if (in_hold.reset_pressed) begin
            returning_to_rest_next = 1'b1;
          end
        end
        MODE_RUNNING: begin
          res.motion_command = CMD_SEQUENCE;
          if (in_hold.stop_pressed) begin
            res.planner_reset = 1'b1;
            mode_next         = MODE_PAUSE;
          end else if (in_hold.sequence_done) begin
            res.planner_reset = 1'b1;
            mode_next         = MODE_READY;
          end
        end
        MODE_FAULT: begin
          res.outputs_off    = 1'b1;
          res.motors_disable = 1'b1;
          if (in_hold.reset_pressed && !in_hold.emergency_active) begin
            res.homing_reset    = 1'b1;
            motors_homed_next   = 1'b0;
            dwell_finished_next = 1'b0;
            mode_next           = MODE_WAIT;
          end
        end
        default: begin
          mode_next = MODE_FAULT;
        end
      endcase
    end
    res.system_state  = mode_next;
    res.state_changed = (mode_next != mode);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_hold <= in_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= res;
    end
  end

  // supervisor state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_INIT;
      emergency_pending <= 1'b0;
      debounce_count    <= 8'd0;
      motors_homed      <= 1'b0;
      dwell_finished    <= 1'b0;
      returning_to_rest <= 1'b0;
      going_to_backoff  <= 1'b0;
    end else if (fire) begin
      mode              <= mode_next;
      motors_homed      <= motors_homed_next;
      dwell_finished    <= dwell_finished_next;
      returning_to_rest <= returning_to_rest_next;
      going_to_backoff  <= going_to_backoff_next;
      if (mode != MODE_INIT) begin
        emergency_pending <= emergency_pending_next;
        debounce_count    <= debounce_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit <= DEBOUNCE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      debounce_limit <= cfg_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rms_checker.sv
// ----------------------------------------------------------------------------
// Robot mode supervisor checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "robot_mode_supervisor_top_assert.svh"

module rms_checker
  import rms_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  `RMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled word changed")
  `RMS_ASSERT_NOW(a_no_init, out_valid, out_word.system_state != MODE_INIT, "init mode reported")
  `RMS_ASSERT_NOW(a_fault_off, out_valid && out_word.system_state == MODE_FAULT, out_word.outputs_off && out_word.motors_disable, "fault without outputs off")
  `RMS_ASSERT_NOW(a_homing_rst, out_valid && out_word.homing_reset, out_word.system_state == MODE_WAIT && out_word.state_changed, "homing reset outside fault exit")
  `RMS_ASSERT_NOW(a_seq_rst, out_valid && out_word.sequence_reset, (out_word.system_state == MODE_RUNNING || out_word.system_state == MODE_HOMING) && out_word.state_changed, "sequence reset without run start")

endmodule

bind robot_mode_supervisor_top rms_checker u_rms_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
